>>> rtl/mf_pkg.sv
// ----------------------------------------------------------------------------
// mf_pkg: shared types, constants and helpers of the 3x3 median filter
// Holds the item structs of both channels, the classified item that the
// front part queues for the back part, and small sorting helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mf_pkg;

  // Default line store depth and queue depths
  localparam int MF_MAX_WIDTH = 2048;
  localparam int MF_FQ_DEPTH  = 4;
  localparam int MF_OQ_DEPTH  = 4;

  // Window edge length (fixed 3x3)
  localparam int WIN = 3;

  // Configuration register width and row counter width
  localparam int CFG_W     = 12;
  localparam int ROW_BITS  = 13;
  localparam logic [ROW_BITS-1:0] ROW_LIMIT = 13'd8191;

  // Register reset values
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } mf_reg_e;

  // Input item
  typedef struct packed {
    logic [7:0] pixel_in;
    logic       frame_start;
    logic       flush;
  } mf_in_t;

  // Result item
  typedef struct packed {
    logic [7:0] pixel_out;
    logic       out_valid;
    logic       out_last;
  } mf_out_t;

  // Classified item handed from front to back (column index travels beside it)
  typedef struct packed {
    logic [7:0] pix;
    logic       flush;
    logic       valid;
    logic       last;
    logic       use_med;
  } mf_cls_t;

  // Sorted triple
  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] md;
    logic [7:0] hi;
  } mf_tri_t;

  // Saturating row increment
  function automatic logic [ROW_BITS-1:0] row_inc(input logic [ROW_BITS-1:0] r);
    row_inc = (r == ROW_LIMIT) ? ROW_LIMIT : r + 1'b1;
  endfunction

  // Three compare-exchange steps
  function automatic mf_tri_t sort3(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c);
    logic [7:0] x, y, z, t;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    sort3 = '{lo: x, md: y, hi: z};
  endfunction

  function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a > b) ? a : b;
    max3 = (m > c) ? m : c;
  endfunction

  function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a < b) ? a : b;
    min3 = (m < c) ? m : c;
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    mf_tri_t s;
    s = sort3(a, b, c);
    med3 = s.md;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mf_fifo.sv
// ----------------------------------------------------------------------------
// mf_fifo: small synchronous queue
// Register-based queue with push/full and pop/empty; head is shown on
// rd_data while empty is low. Push into a full queue and pop of an empty
// queue are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module mf_fifo import mf_pkg::*; #(
  parameter int DEPTH = MF_FQ_DEPTH,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wr_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rd_data,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  // Handshake qualification
  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("accepted push did not grow the queue");

  a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop && !do_push |=> !full)
    else $error("queue still full after a pop");

endmodule

`default_nettype wire

>>> rtl/mf_front.sv
// ----------------------------------------------------------------------------
// mf_front: configuration registers, raster counters and item classifier
// Tracks column and row of each accepted item and works out which frame
// position its result belongs to: valid, last, border or median.
// ----------------------------------------------------------------------------
`default_nettype none

module mf_front import mf_pkg::*; #(
  parameter int MAX_WIDTH = MF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_addr,
  input  logic [CFG_W-1:0]               cfg_wdata,
  input  logic                           in_push,
  input  mf_in_t                         in_data,
  input  logic                           fq_full,
  output logic                           fq_push,
  output mf_cls_t                        fq_cls,
  output logic [$clog2(MAX_WIDTH)-1:0]   fq_ci
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

  // Clamp a width value to 3..MAX_WIDTH
  function automatic logic [WW-1:0] clamp_w(input logic [CFG_W-1:0] v);
    logic [WW-1:0] e;
    e = WW'(v);
    if (e < WW'(3)) begin
      clamp_w = WW'(3);
    end else if (e > WW'(MAX_WIDTH)) begin
      clamp_w = WW'(MAX_WIDTH);
    end else begin
      clamp_w = e;
    end
  endfunction

  function automatic logic [CFG_W-1:0] clamp_h(input logic [CFG_W-1:0] v);
    clamp_h = (v < CFG_W'(3)) ? CFG_W'(3) : v;
  endfunction

  localparam logic [WW-1:0]    W_RST = clamp_w(CFG_W'(WIDTH_RESET));
  localparam logic [CFG_W-1:0] H_RST = clamp_h(CFG_W'(HEIGHT_RESET));

  logic [WW-1:0]       w_eff_r, wm1_r;
  logic [CFG_W-1:0]    h_eff_r, hm1_r;
  logic [CW-1:0]       col_r, col_nxt;
  logic [ROW_BITS-1:0] row_r, row_nxt;

  logic [CW-1:0]       c0, c;
  logic [ROW_BITS-1:0] r0, r, y;
  logic [WW-1:0]       c_ext, c_inc, x;
  logic                have, valid, last, border;

  // Hold effective (clamped) frame size and its last index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= W_RST;
      wm1_r   <= W_RST - 1'b1;
      h_eff_r <= H_RST;
      hm1_r   <= H_RST - 1'b1;
    end else if (cfg_we) begin
      unique case (mf_reg_e'(cfg_addr))
        REG_IMAGE_WIDTH: begin
          w_eff_r <= clamp_w(cfg_wdata);
          wm1_r   <= clamp_w(cfg_wdata) - 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          h_eff_r <= clamp_h(cfg_wdata);
          hm1_r   <= clamp_h(cfg_wdata) - 1'b1;
        end
      endcase
    end
  end

  // Locate the item and classify its result position
  always_comb begin
    c0 = in_data.frame_start ? '0 : col_r;
    r0 = in_data.frame_start ? '0 : row_r;
    if (WW'(c0) >= w_eff_r) begin
      c = '0;
      r = row_inc(r0);
    end else begin
      c = c0;
      r = r0;
    end
    c_ext = WW'(c);
    if (c != '0) begin
      have = (r != '0);
      y    = r - 1'b1;
      x    = c_ext - 1'b1;
    end else begin
      have = (r >= ROW_BITS'(2));
      y    = r - ROW_BITS'(2);
      x    = wm1_r;
    end
    valid  = have && (y < ROW_BITS'(h_eff_r));
    last   = valid && (y == ROW_BITS'(hm1_r)) && (x == wm1_r);
    border = (c == '0) || (y == '0) || (y == ROW_BITS'(hm1_r)) ||
             (x == '0) || (x == wm1_r);
    c_inc  = c_ext + 1'b1;
    if (c_inc >= w_eff_r) begin
      col_nxt = '0;
      row_nxt = row_inc(r);
    end else begin
      col_nxt = c_inc[CW-1:0];
      row_nxt = r;
    end
  end

  // Queue the classified item
  assign fq_push        = in_push && !fq_full;
  assign fq_ci          = c;
  assign fq_cls.pix     = in_data.pixel_in;
  assign fq_cls.flush   = in_data.flush;
  assign fq_cls.valid   = valid;
  assign fq_cls.last    = last;
  assign fq_cls.use_med = valid && !border;

  // Advance counters on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (fq_push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mf_back.sv
// ----------------------------------------------------------------------------
// mf_back: line stores, 3x3 window and median pipeline
// Reads both line stores for the queued item, shifts the window, writes
// the stores back, then takes the median in two registered steps
// (sort rows, then max/med/min of the sorted columns) and a med3 of those three.
// ----------------------------------------------------------------------------
`default_nettype none

module mf_back import mf_pkg::*; #(
  parameter int MAX_WIDTH = MF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fq_empty,
  input  mf_cls_t                      fq_cls,
  input  logic [$clog2(MAX_WIDTH)-1:0] fq_ci,
  output logic                         fq_pop,
  input  logic                         oq_full,
  output logic                         oq_push,
  output mf_out_t                      oq_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  // Line stores
  logic [7:0] store_a [MAX_WIDTH];
  logic [7:0] store_b [MAX_WIDTH];

  logic adv;

  // Read stage
  logic          r_v_r;
  mf_cls_t       r_cls_r;
  logic [CW-1:0] r_ci_r;
  logic [7:0]    rd_a_r, rd_b_r;
  logic          r_byp_r, byp_nxt;
  logic [7:0]    r_byp_a_r, r_byp_b_r;

  // Window
  logic [WIN-1:0][WIN-1:0][7:0] win_r, win_nxt;
  logic [7:0] top, mid, bot;
  logic       wr_en;
  mf_tri_t    srt [WIN];

  // Sort stage
  logic       p1_v_r;
  mf_cls_t    p1_cls_r;
  logic [7:0] p1_ctr_r;
  mf_tri_t    p1_tri_r [WIN];

  // Select stage
  logic       p2_v_r;
  mf_cls_t    p2_cls_r;
  logic [7:0] p2_ctr_r;
  logic [7:0] p2_lo_r, p2_md_r, p2_hi_r;

  // Stall the whole pipe when the last stage cannot drain
  assign adv     = !(p2_v_r && oq_full);
  assign fq_pop  = adv && !fq_empty;
  assign wr_en   = adv && r_v_r && !r_cls_r.flush;
  assign byp_nxt = wr_en && (r_ci_r == fq_ci);

  // Shift the window and sort its rows
  always_comb begin
    top = r_byp_r ? r_byp_b_r : rd_b_r;
    mid = r_byp_r ? r_byp_a_r : rd_a_r;
    bot = r_cls_r.flush ? 8'd0 : r_cls_r.pix;
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN - 1; j++) begin
        win_nxt[i][j] = win_r[i][j+1];
      end
    end
    win_nxt[0][WIN-1] = top;
    win_nxt[1][WIN-1] = mid;
    win_nxt[2][WIN-1] = bot;
    for (int i = 0; i < WIN; i++) begin
      srt[i] = sort3(win_nxt[i][0], win_nxt[i][1], win_nxt[i][2]);
    end
  end

  // Read-first line store ports
  always_ff @(posedge clk) begin
    if (fq_pop) begin
      rd_a_r <= store_a[fq_ci];
      rd_b_r <= store_b[fq_ci];
    end
    if (wr_en) begin
      store_a[r_ci_r] <= r_cls_r.pix;
      store_b[r_ci_r] <= mid;
    end
  end

  // Stage valids and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r   <= 1'b0;
      r_byp_r <= 1'b0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      win_r   <= '0;
    end else if (adv) begin
      r_v_r  <= !fq_empty;
      p1_v_r <= r_v_r;
      p2_v_r <= p1_v_r;
      if (fq_pop) begin
        r_byp_r <= byp_nxt;
      end
      if (r_v_r) begin
        win_r <= win_nxt;
      end
    end
  end

  // Advance payload through the stages
  always_ff @(posedge clk) begin
    if (adv) begin
      if (fq_pop) begin
        r_cls_r   <= fq_cls;
        r_ci_r    <= fq_ci;
        r_byp_a_r <= r_cls_r.pix;
        r_byp_b_r <= mid;
      end
      p1_cls_r <= r_cls_r;
      p1_ctr_r <= win_nxt[1][1];
      for (int i = 0; i < WIN; i++) begin
        p1_tri_r[i] <= srt[i];
      end
      p2_cls_r <= p1_cls_r;
      p2_ctr_r <= p1_ctr_r;
      p2_lo_r  <= max3(p1_tri_r[0].lo, p1_tri_r[1].lo, p1_tri_r[2].lo);
      p2_md_r  <= med3(p1_tri_r[0].md, p1_tri_r[1].md, p1_tri_r[2].md);
      p2_hi_r  <= min3(p1_tri_r[0].hi, p1_tri_r[1].hi, p1_tri_r[2].hi);
    end
  end

  // Form the result item
  always_comb begin
    oq_push           = adv && p2_v_r;
    oq_data.out_valid = p2_cls_r.valid;
    oq_data.out_last  = p2_cls_r.last;
    if (!p2_cls_r.valid) begin
      oq_data.pixel_out = 8'd0;
    end else if (p2_cls_r.use_med) begin
      oq_data.pixel_out = med3(p2_lo_r, p2_md_r, p2_hi_r);
    end else begin
      oq_data.pixel_out = p2_ctr_r;
    end
  end

  a_win_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(win_r))
    else $error("window moved during a stall");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    p1_v_r && (p1_cls_r.last || p1_cls_r.use_med) |-> p1_cls_r.valid)
    else $error("last or median item not marked valid");

  a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
    adv && p1_v_r |=> p2_v_r)
    else $error("item lost between sort and select stages");

endmodule

`default_nettype wire

>>> rtl/median_filter_3x3.sv
// ----------------------------------------------------------------------------
// median_filter_3x3: streaming 3x3 median filter for 8-bit grey pixels
// Input queue side: push/full, item = pixel, frame start mark, flush mark.
// Result queue side: empty/pop, item = median pixel, valid mark, last mark.
// Every accepted item gives exactly one result, which belongs to the frame
// position one row and one column behind it; flush items drain the frame.
// Border positions pass the original pixel, others get the 3x3 median.
// Configuration: cfg_we with cfg_addr 0 = image width, 1 = image height,
// written while the block is idle.
// Throughput: one item per cycle; a new item is taken every cycle while
// the input queue has room.
// Path: each item passes the input queue, the line store read, the row sort
// and the column select stages, then the result queue.
// Stall: when pop stays low the output queue fills, the back pipeline
// holds, the input queue fills and full rises; nothing is dropped.
// Reset: queues empty, counters zero, window zero, width 640, height 480.
// Line stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filter_3x3 import mf_pkg::*; #(
  parameter int MAX_WIDTH = MF_MAX_WIDTH,
  parameter int FQ_DEPTH  = MF_FQ_DEPTH,
  parameter int OQ_DEPTH  = MF_OQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_push,
  input  mf_in_t           in_data,
  output logic             in_full,
  input  logic             out_pop,
  output mf_out_t          out_data,
  output logic             out_empty
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int FQ_W = $bits(mf_cls_t) + CW;

  logic            fq_full, fq_push, fq_pop, fq_empty;
  mf_cls_t         fe_cls, fq_cls;
  logic [CW-1:0]   fe_ci, fq_ci;
  logic [FQ_W-1:0] fq_rd;
  logic            oq_full, oq_push;
  mf_out_t         oq_data;

  assign in_full = fq_full;

  // Counters and classification
  mf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .fq_full   (fq_full),
    .fq_push   (fq_push),
    .fq_cls    (fe_cls),
    .fq_ci     (fe_ci)
  );

  // Queue between front and back
  mf_fifo #(.DEPTH(FQ_DEPTH), .DW(FQ_W)) u_fq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .wr_data ({fe_cls, fe_ci}),
    .full    (fq_full),
    .pop     (fq_pop),
    .rd_data (fq_rd),
    .empty   (fq_empty)
  );

  assign fq_cls = mf_cls_t'(fq_rd[FQ_W-1:CW]);
  assign fq_ci  = fq_rd[CW-1:0];

  // Line stores, window and median
  mf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .fq_empty (fq_empty),
    .fq_cls   (fq_cls),
    .fq_ci    (fq_ci),
    .fq_pop   (fq_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_data  (oq_data)
  );

  // Result queue
  mf_fifo #(.DEPTH(OQ_DEPTH), .DW($bits(mf_out_t))) u_oq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (oq_push),
    .wr_data (oq_data),
    .full    (oq_full),
    .pop     (out_pop),
    .rd_data (out_data),
    .empty   (out_empty)
  );

endmodule

`default_nettype wire

>>> verif/tb_median_filter_3x3.sv
// ----------------------------------------------------------------------------
// tb_median_filter_3x3: self-checking bench for the 3x3 median filter
// Streams raster frames through the push/full side, pops results with
// random stalls, and compares every result against a cycle-free model of
// the line stores, window and frame counters kept in a scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_median_filter_3x3 import mf_pkg::*;;

  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 250;
  localparam int FILL_WIDTH = 64;

  // Scoreboard: mirrors the filter state and queues the expected results
  class median_tracker;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [7:0] recent_row [MF_MAX_WIDTH];
    logic [7:0] older_row [MF_MAX_WIDTH];
    logic [7:0] win [3][3];
    int unsigned col;
    int unsigned row;
    mf_out_t due_pixels [$];
    int errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      width_reg = CFG_W'(WIDTH_RESET);
      height_reg = CFG_W'(HEIGHT_RESET);
      foreach (recent_row[i]) begin
        recent_row[i] = '0;
        older_row[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col = 0;
      row = 0;
    endfunction

    function void set_reg(mf_reg_e idx, logic [CFG_W-1:0] val);
      if (idx == REG_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function int pending();
      return due_pixels.size();
    endfunction

    function int unsigned next_row(int unsigned r);
      return (r < 8191) ? r + 1 : 8191;
    endfunction

    function logic [7:0] window_median();
      logic [7:0] v [9];
      logic [7:0] t;
      int i;
      int j;
      for (i = 0; i < 9; i++) v[i] = win[i / 3][i % 3];
      // insertion sort, take the middle
      for (i = 1; i < 9; i++) begin
        t = v[i];
        j = i;
        while (j > 0 && v[j - 1] > t) begin
          v[j] = v[j - 1];
          j--;
        end
        v[j] = t;
      end
      return v[4];
    endfunction

    // Advance the model by one accepted item and queue its result
    function void note_item(mf_in_t it);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned y;
      int unsigned x;
      int k;
      bit have;
      bit ok;
      logic [7:0] prev_right;
      logic [7:0] top;
      logic [7:0] mid;
      mf_out_t res;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > MF_MAX_WIDTH) w = MF_MAX_WIDTH;
      h = height_reg;
      if (h < 3) h = 3;
      if (it.frame_start) begin
        col = 0;
        row = 0;
      end
      c = col;
      r = row;
      // wrap a column left over from a wider setting
      if (c >= w) begin
        c = 0;
        r = next_row(r);
      end
      prev_right = win[1][2];
      top = older_row[c];
      mid = recent_row[c];
      for (k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = it.flush ? 8'd0 : it.pixel_in;
      if (!it.flush) begin
        older_row[c] = mid;
        recent_row[c] = it.pixel_in;
      end
      // locate the position one row and one column behind
      have = 1'b0;
      y = 0;
      x = 0;
      if (c >= 1) begin
        if (r >= 1) begin
          have = 1'b1;
          y = r - 1;
          x = c - 1;
        end
      end else if (r >= 2) begin
        have = 1'b1;
        y = r - 2;
        x = w - 1;
      end
      ok = have && (y < h);
      res = '0;
      res.out_valid = ok;
      res.out_last = ok && (y == h - 1) && (x == w - 1);
      if (ok) begin
        if (c == 0) res.pixel_out = prev_right;
        else if (y == 0 || y == h - 1 || x == 0 || x == w - 1) res.pixel_out = win[1][1];
        else res.pixel_out = window_median();
      end
      c++;
      if (c >= w) begin
        c = 0;
        r = next_row(r);
      end
      col = c;
      row = r;
      due_pixels = {due_pixels, res};
    endfunction

    // Compare one popped result with the oldest expectation
    function void check_pixel(mf_out_t got);
      mf_out_t want;
      if (due_pixels.size() == 0) begin
        $error("unexpected result: pixel_out=%0d out_valid=%0b out_last=%0b",
               got.pixel_out, got.out_valid, got.out_last);
        errors++;
        return;
      end
      want = due_pixels.pop_front();
      if (got.pixel_out !== want.pixel_out) begin
        $error("pixel_out: expected %0d, got %0d", want.pixel_out, got.pixel_out);
        errors++;
      end
      if (got.out_valid !== want.out_valid) begin
        $error("out_valid: expected %0b, got %0b", want.out_valid, got.out_valid);
        errors++;
      end
      if (got.out_last !== want.out_last) begin
        $error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [0:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_push;
  mf_in_t in_data;
  logic in_full;
  logic out_pop;
  mf_out_t out_data;
  logic out_empty;

  median_tracker tracker = new();
  int calm [2];
  int items_sent;
  int pops_done;

  median_filter_3x3 uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_pop  (out_pop),
    .out_data (out_data),
    .out_empty(out_empty)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Draw a per-item wait; index 0 is the sender, 1 the receiver
  function automatic int draw_gap(input bit side);
    if (calm[side] > 0) begin
      calm[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm[side] = $urandom_range(10, 60);
    return $urandom_range(0, 7);
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_item(input logic [7:0] pix, input bit fs, input bit fl);
    mf_in_t it;
    int gap;
    it.pixel_in = pix;
    it.frame_start = fs;
    it.flush = fl;
    gap = draw_gap(1'b0);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    tracker.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop push and wait until every expected result has been popped
  task automatic wait_idle();
    in_push <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input mf_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    tracker.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic configure(input int unsigned w_val, input int unsigned h_val);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w_val[CFG_W-1:0]);
    write_reg(REG_IMAGE_HEIGHT, h_val[CFG_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  // Send one frame plus its drain; noisy frames may end early and get flushes,
  // restarts, short drains or extra items after the drain
  task automatic run_frame(input int w, input int h, input bit noisy);
    int n;
    int drain;
    int extra;
    int pick;
    extra = 0;
    for (n = 0; n < w * h; n++) begin
      if (noisy && n > 0 && $urandom_range(0, 149) == 0) return;
      if (noisy && n > 0 && $urandom_range(0, 39) == 0)
        send_item(rand_pixel(), $urandom_range(0, 3) == 0, 1'b1);
      else
        send_item(rand_pixel(), n == 0, 1'b0);
    end
    drain = w + 1;
    if (noisy) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) drain = $urandom_range(0, w);
      else if (pick == 1) extra = $urandom_range(1, 3);
    end
    repeat (drain) send_item(rand_pixel(), 1'b0, 1'b1);
    repeat (extra) send_item(rand_pixel(), 1'b0, 1'b0);
  endtask

  // Result side: pop with random stalls and two long hold-offs
  task automatic take_result();
    int gap;
    if (pops_done == 100 || pops_done == 400) gap = HOLD_CYCLES;
    else gap = draw_gap(1'b1);
    if (gap > 0) begin
      out_pop <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    out_pop <= 1'b1;
    do @(posedge clk); while (out_empty);
    tracker.check_pixel(out_data);
    pops_done++;
    @(negedge clk);
  endtask

  initial begin
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever take_result();
  end

  // Stimulus
  initial begin
    logic [7:0] pattern [9];
    int base;
    int w;
    int h;
    int w_val;
    int h_val;
    pattern = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd0, 8'd255};
    calm = '{0, 0};
    items_sent = 0;
    pops_done = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Width clamped down, height raised; a short first row only
    configure(4095, 0);
    send_item(rand_pixel(), 1'b1, 1'b0);
    repeat (15) send_item(rand_pixel(), 1'b0, 1'b0);

    // Fill both line stores across the widest random frame
    configure(FILL_WIDTH, 3);
    run_frame(FILL_WIDTH, 3, 1'b0);

    // Smallest frame with extreme pixels, full drain, then items past it
    configure(1, 2);
    foreach (pattern[i]) send_item(pattern[i], i == 0, 1'b0);
    repeat (4) send_item(8'd255, 1'b0, 1'b1);
    send_item(8'd255, 1'b0, 1'b0);
    send_item(8'd0, 1'b0, 1'b0);

    // Frame start on a flush, then a restart in the middle of a frame
    send_item(8'd255, 1'b1, 1'b1);
    repeat (3) send_item(rand_pixel(), 1'b0, 1'b0);
    send_item(rand_pixel(), 1'b1, 1'b0);
    repeat (2) send_item(rand_pixel(), 1'b0, 1'b0);

    // Narrow the width while the column counter sits beyond it
    configure(8, 4095);
    send_item(rand_pixel(), 1'b1, 1'b0);
    repeat (5) send_item(rand_pixel(), 1'b0, 1'b0);
    configure(4, 4095);
    repeat (5) send_item(rand_pixel(), 1'b0, 1'b0);

    // Random frames, mostly small, a few wider, some out-of-range settings
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, FILL_WIDTH) : $urandom_range(3, 12);
      h = $urandom_range(3, 6);
      w_val = w;
      h_val = h;
      if ($urandom_range(0, 9) == 0) begin
        w = 3;
        w_val = $urandom_range(0, 2);
      end
      if ($urandom_range(0, 9) == 0) begin
        h = 3;
        h_val = $urandom_range(0, 2);
      end
      configure(w_val, h_val);
      repeat ($urandom_range(1, 3)) run_frame(w, h, 1'b1);
    end

    wait_idle();
    repeat (16) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("median_filter_3x3 verification clean");
    end else begin
      $display("median_filter_3x3 verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("median_filter_3x3 verification failed");
    $finish;
  end

endmodule

`default_nettype wire
